// ===== src/mnpp_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the network midi packet parser
// no dependencies; imported by mnpp_parser, mnpp_result_fifo and the top level
package mnpp_pkg;

	localparam int HEADER_BYTES = 20;
	localparam int LEN_W        = 16;
	localparam int HDR_W        = 128;
	localparam int ADDR_W       = 5;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = 2;

	// result kinds
	localparam logic [2:0] KIND_HEADER      = 3'd0;
	localparam logic [2:0] KIND_MIDI        = 3'd1;
	localparam logic [2:0] KIND_CONTEXT     = 3'd2;
	localparam logic [2:0] KIND_TOO_SHORT   = 3'd3;
	localparam logic [2:0] KIND_BAD_MAGIC   = 3'd4;
	localparam logic [2:0] KIND_BAD_VERSION = 3'd5;

	// register indexes
	localparam logic [2:0] REG_MAGIC    = 3'd0;
	localparam logic [2:0] REG_VERSION  = 3'd1;
	localparam logic [2:0] REG_CTX_MASK = 3'd2;
	localparam logic [2:0] REG_CTX_TYPE = 3'd3;
	localparam logic [2:0] REG_CTX_MIN  = 3'd4;

	localparam logic [7:0] CTX_MIN_RESET = 8'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  payload_byte;
		logic [7:0]  flags_out;
		logic [31:0] source_hash;
		logic [31:0] dest_hash;
		logic [15:0] sequence_number;
		logic [31:0] timestamp_us;
		logic [15:0] device_number;
		logic        packet_end;
	} result_t;

	typedef struct packed {
		logic [15:0] magic_value;
		logic [7:0]  version_value;
		logic [7:0]  context_flag_mask;
		logic [7:0]  context_type_code;
		logic [7:0]  context_min_length;
	} cfg_t;

	// up to two results written into the queue in one cycle
	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} push_t;

endpackage

// ===== src/mnpp_parser.sv =====
`timescale 1ns / 1ps
// input register and per-byte packet parsing, emitting up to two results per item
// depends on mnpp_pkg
module mnpp_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mnpp_pkg::cfg_t             cfg,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       first_byte,
	input  logic [mnpp_pkg::LEN_W-1:0] packet_length,
	input  logic                       room,
	output mnpp_pkg::push_t            push
);
	import mnpp_pkg::*;

	// input register
	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             first_s1;
	logic [LEN_W-1:0] length_s1;

	// packet state
	logic [LEN_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;
	logic [HDR_W-1:0] hdr_q;
	logic [7:0]       flags_q;
	logic [7:0]       pend_q;
	logic             pend_valid_q;
	logic             in_ctx_q;
	logic             discard_q;

	logic             proc;

	logic [LEN_W-1:0] pos_n;
	logic [LEN_W-1:0] len_n;
	logic [HDR_W-1:0] hdr_n;
	logic [7:0]       flags_n;
	logic [7:0]       pend_n;
	logic             pend_valid_n;
	logic             in_ctx_n;
	logic             discard_n;
	push_t            push_c;

	assign proc       = valid_s1 && room;
	assign item_ready = !valid_s1 || room;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			data_s1   <= data_byte;
			first_s1  <= first_byte;
			length_s1 <= packet_length;
		end
	end

	// byte parsing
	always_comb begin
		logic [LEN_W-1:0] p;
		logic             last;
		logic             fresh;
		logic [LEN_W:0]   ext_end;
		result_t          r;
		result_t          hdr_res;
		pos_n        = pos_q;
		len_n        = len_q;
		hdr_n        = hdr_q;
		flags_n      = flags_q;
		pend_n       = pend_q;
		pend_valid_n = pend_valid_q;
		in_ctx_n     = in_ctx_q;
		discard_n    = discard_q;
		push_c       = '0;
		p            = '0;
		last         = 1'b0;
		fresh        = 1'b1;
		ext_end      = '0;
		r            = '0;
		hdr_res      = '0;

		if (first_s1) begin
			pos_n        = '0;
			len_n        = length_s1;
			hdr_n        = '0;
			flags_n      = '0;
			pend_n       = '0;
			pend_valid_n = 1'b0;
			in_ctx_n     = 1'b0;
			discard_n    = 1'b0;
		end

		if (first_s1 && length_s1 < LEN_W'(HEADER_BYTES)) begin
			// too short: report and drop the rest
			r.kind       = KIND_TOO_SHORT;
			r.packet_end = 1'b1;
			push_c.count = 2'd1;
			push_c.res0  = r;
			discard_n    = 1'b1;
		end else if (!discard_n && pos_n < len_n) begin
			p     = pos_n;
			pos_n = p + 1'b1;
			last  = (pos_n == len_n);

			if (p < LEN_W'(HEADER_BYTES)) begin
				// header bytes shift into the field register
				hdr_n = {hdr_n[HDR_W-9:0], data_s1};
				if (p == LEN_W'(1) && {hdr_n[15:8], data_s1} != cfg.magic_value) begin
					r.kind       = KIND_BAD_MAGIC;
					r.packet_end = 1'b1;
					push_c.count = 2'd1;
					push_c.res0  = r;
					discard_n    = 1'b1;
				end else if (p == LEN_W'(2) && data_s1 != cfg.version_value) begin
					r.kind       = KIND_BAD_VERSION;
					r.packet_end = 1'b1;
					push_c.count = 2'd1;
					push_c.res0  = r;
					discard_n    = 1'b1;
				end else begin
					if (p == LEN_W'(3)) begin
						flags_n = data_s1;
					end
					if (p == LEN_W'(HEADER_BYTES - 1)) begin
						hdr_res.kind            = KIND_HEADER;
						hdr_res.flags_out       = flags_n;
						hdr_res.source_hash     = hdr_n[127:96];
						hdr_res.dest_hash       = hdr_n[95:64];
						hdr_res.sequence_number = hdr_n[63:48];
						hdr_res.timestamp_us    = hdr_n[47:16];
						hdr_res.device_number   = hdr_n[15:0];
						hdr_res.packet_end      = last;
						push_c.count            = 2'd1;
						push_c.res0             = hdr_res;
					end
				end
			end else if (in_ctx_n) begin
				// inside the context part
				r.kind         = KIND_CONTEXT;
				r.payload_byte = data_s1;
				r.packet_end   = last;
				push_c.count   = 2'd1;
				push_c.res0    = r;
			end else begin
				// resolve a held type byte using this byte as the length
				if (pend_valid_n) begin
					pend_valid_n = 1'b0;
					ext_end      = {1'b0, p} - 1'b1 + {{(LEN_W - 7){1'b0}}, data_s1};
					if (ext_end <= {1'b0, len_n} && data_s1 >= cfg.context_min_length) begin
						in_ctx_n                   = 1'b1;
						fresh                      = 1'b0;
						push_c.count               = 2'd2;
						push_c.res0.kind           = KIND_CONTEXT;
						push_c.res0.payload_byte   = pend_n;
						push_c.res1.kind           = KIND_CONTEXT;
						push_c.res1.payload_byte   = data_s1;
						push_c.res1.packet_end     = last;
					end else begin
						push_c.count             = 2'd1;
						push_c.res0.kind         = KIND_MIDI;
						push_c.res0.payload_byte = pend_n;
					end
				end
				// a fresh byte is either held back or goes out as midi
				if (fresh) begin
					if ((flags_n & cfg.context_flag_mask) != 8'd0 &&
						data_s1 == cfg.context_type_code && !last) begin
						pend_n       = data_s1;
						pend_valid_n = 1'b1;
					end else if (push_c.count == 2'd1) begin
						push_c.count             = 2'd2;
						push_c.res1.kind         = KIND_MIDI;
						push_c.res1.payload_byte = data_s1;
						push_c.res1.packet_end   = last;
					end else begin
						push_c.count             = 2'd1;
						push_c.res0.kind         = KIND_MIDI;
						push_c.res0.payload_byte = data_s1;
						push_c.res0.packet_end   = last;
					end
				end
			end
		end
	end

	// packet state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			len_q        <= '0;
			hdr_q        <= '0;
			flags_q      <= '0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			in_ctx_q     <= 1'b0;
			discard_q    <= 1'b0;
		end else if (proc) begin
			pos_q        <= pos_n;
			len_q        <= len_n;
			hdr_q        <= hdr_n;
			flags_q      <= flags_n;
			pend_q       <= pend_n;
			pend_valid_q <= pend_valid_n;
			in_ctx_q     <= in_ctx_n;
			discard_q    <= discard_n;
		end
	end

	always_comb begin
		push = push_c;
		if (!proc) begin
			push.count = 2'd0;
		end
	end

endmodule

// ===== src/mnpp_result_fifo.sv =====
`timescale 1ns / 1ps
// four-entry result queue taking up to two results per cycle and giving one
// depends on mnpp_pkg
module mnpp_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  mnpp_pkg::push_t   push,
	output logic              room,
	output logic              result_valid,
	input  logic              result_ready,
	output mnpp_pkg::result_t head
);
	import mnpp_pkg::*;

	result_t            mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               pop;

	assign result_valid = (count_q != '0);
	assign pop          = result_valid && result_ready;
	assign room         = (count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
	assign head         = mem[rd_ptr_q];

	// storage writes
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_ptr_q] <= push.res0;
		end
		if (push.count == 2'd2) begin
			mem[wr_ptr_q + 1'b1] <= push.res1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule

// ===== src/midi_net_packet_parser_unit.sv =====
`timescale 1ns / 1ps
// network midi packet parser: one packet byte per item, header and payload results
// each result passes the input register and then the result queue before it is offered
// throughput: one byte per cycle; a byte may yield up to two results, queued four deep,
// and the input stalls while more than two results are waiting
// reset: all packet state and the queue clear; registers return to their reset values
// depends on mnpp_pkg, mnpp_parser, mnpp_result_fifo
module midi_net_packet_parser_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mnpp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        first_byte,
	input  logic [mnpp_pkg::LEN_W-1:0]  packet_length,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [2:0]                  kind,
	output logic [7:0]                  payload_byte,
	output logic [7:0]                  flags_out,
	output logic [31:0]                 source_hash,
	output logic [31:0]                 dest_hash,
	output logic [15:0]                 sequence_number,
	output logic [31:0]                 timestamp_us,
	output logic [15:0]                 device_number,
	output logic                        packet_end
);
	import mnpp_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       room;
	push_t      push;
	result_t    head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{16'd0, 8'd0, 8'd0, 8'd0, CTX_MIN_RESET};
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_MAGIC:    cfg_q.magic_value        <= pwdata[15:0];
				REG_VERSION:  cfg_q.version_value      <= pwdata[7:0];
				REG_CTX_MASK: cfg_q.context_flag_mask  <= pwdata[7:0];
				REG_CTX_TYPE: cfg_q.context_type_code  <= pwdata[7:0];
				REG_CTX_MIN:  cfg_q.context_min_length <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_MAGIC:    prdata = {16'd0, cfg_q.magic_value};
			REG_VERSION:  prdata = {24'd0, cfg_q.version_value};
			REG_CTX_MASK: prdata = {24'd0, cfg_q.context_flag_mask};
			REG_CTX_TYPE: prdata = {24'd0, cfg_q.context_type_code};
			REG_CTX_MIN:  prdata = {24'd0, cfg_q.context_min_length};
			default:      prdata = 32'd0;
		endcase
	end

	mnpp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.packet_length (packet_length),
		.room          (room),
		.push          (push)
	);

	mnpp_result_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.head         (head)
	);

	// result fields
	assign kind            = head.kind;
	assign payload_byte    = head.payload_byte;
	assign flags_out       = head.flags_out;
	assign source_hash     = head.source_hash;
	assign dest_hash       = head.dest_hash;
	assign sequence_number = head.sequence_number;
	assign timestamp_us    = head.timestamp_us;
	assign device_number   = head.device_number;
	assign packet_end      = head.packet_end;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for midi_net_packet_parser_unit: directed rows, then random packets
// depends on mnpp_pkg and the parser rtl; untyped results are checked against the model here
module tb_top;
	import mnpp_pkg::*;

	localparam int          CYCLE_LIMIT   = 800000;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          PHASE_BYTES   = 300;
	localparam logic [2:0]  KIND_NONE     = 3'd7;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic [15:0] len;
		logic [2:0]  want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                item_valid = 1'b0;
	logic                item_ready;
	logic [7:0]          data_byte = '0;
	logic                first_byte = 1'b0;
	logic [LEN_W-1:0]    packet_length = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic [2:0]          kind;
	logic [7:0]          payload_byte;
	logic [7:0]          flags_out;
	logic [31:0]         source_hash;
	logic [31:0]         dest_hash;
	logic [15:0]         sequence_number;
	logic [31:0]         timestamp_us;
	logic [15:0]         device_number;
	logic                packet_end;

	// packet model state
	cfg_t                live_cfg;
	int                  pkt_pos = 0;
	int                  pkt_len = 0;
	logic [127:0]        hdr_bytes = '0;
	logic [7:0]          pkt_flags = '0;
	logic [7:0]          held_type_byte = '0;
	bit                  held_valid = 1'b0;
	bit                  ctx_active = 1'b0;
	bit                  dropping = 1'b0;

	result_t             expected_results[$];
	int                  mismatches = 0;
	int unsigned         cycle_count = 0;
	int                  sender_idle_pct = 0;
	int                  recv_stall_pct = 0;

	// directed rows; typed kinds are checked as written, the rest go through the model
	stim_row_t directed_rows [29] = '{
		'{8'h5A, 1'b1, 16'd0,    KIND_TOO_SHORT},	// zero length
		'{8'hA5, 1'b1, 16'd19,   KIND_TOO_SHORT},	// one byte short of a header
		'{8'hAB, 1'b1, 16'hFFFF, KIND_NONE},	// longest length
		'{8'hCD, 1'b0, 16'h0000, KIND_BAD_MAGIC},
		'{8'h00, 1'b0, 16'h0000, KIND_NONE},	// dropped after the reject
		'{8'h00, 1'b1, 16'd20,   KIND_NONE},
		'{8'h00, 1'b0, 16'h0000, KIND_NONE},
		'{8'h01, 1'b0, 16'h0000, KIND_BAD_VERSION},
		'{8'h00, 1'b1, 16'd5000, KIND_NONE},	// abandoned by the next first byte
		'{8'h00, 1'b1, 16'd20,   KIND_NONE},
		'{8'h00, 1'b0, 16'h0000, KIND_NONE},
		'{8'h00, 1'b0, 16'h0000, KIND_NONE},
		// flags and every header field all ones
		'{8'hFF, 1'b0, 16'h0, KIND_NONE}, '{8'hFF, 1'b0, 16'h0, KIND_NONE},
		'{8'hFF, 1'b0, 16'h0, KIND_NONE}, '{8'hFF, 1'b0, 16'h0, KIND_NONE},
		'{8'hFF, 1'b0, 16'h0, KIND_NONE}, '{8'hFF, 1'b0, 16'h0, KIND_NONE},
		'{8'hFF, 1'b0, 16'h0, KIND_NONE}, '{8'hFF, 1'b0, 16'h0, KIND_NONE},
		'{8'hFF, 1'b0, 16'h0, KIND_NONE}, '{8'hFF, 1'b0, 16'h0, KIND_NONE},
		'{8'hFF, 1'b0, 16'h0, KIND_NONE}, '{8'hFF, 1'b0, 16'h0, KIND_NONE},
		'{8'hFF, 1'b0, 16'h0, KIND_NONE}, '{8'hFF, 1'b0, 16'h0, KIND_NONE},
		'{8'hFF, 1'b0, 16'h0, KIND_NONE}, '{8'hFF, 1'b0, 16'h0, KIND_NONE},
		'{8'hFF, 1'b0, 16'h0, KIND_HEADER}
	};

	midi_net_packet_parser_unit DUT (.*);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom());
	endfunction

	function automatic result_t byte_result(input logic [2:0] k, input logic [7:0] b);
		result_t r;
		r = '0;
		r.kind = k;
		r.payload_byte = b;
		return r;
	endfunction

	// a rejected packet: one result, then the rest of the packet is dropped
	function automatic result_t reject(input logic [2:0] k);
		result_t r;
		r = byte_result(k, 8'h00);
		r.packet_end = 1'b1;
		dropping = 1'b1;
		return r;
	endfunction

	// results expected for one accepted byte; returns how many
	function automatic int parse_byte(input logic [7:0] d, input logic fb, input logic [15:0] len,
			output result_t r0, output result_t r1);
		int        p;
		int        n;
		bit        last;
		bit        fresh;
		logic [7:0] prev_low;
		result_t   outs [2];
		outs[0] = '0;
		outs[1] = '0;
		r0 = '0;
		r1 = '0;
		n = 0;
		if (fb) begin
			pkt_pos = 0;
			pkt_len = int'(len);
			hdr_bytes = '0;
			pkt_flags = '0;
			held_type_byte = '0;
			held_valid = 1'b0;
			ctx_active = 1'b0;
			dropping = 1'b0;
			if (pkt_len < HEADER_BYTES) begin
				r0 = reject(KIND_TOO_SHORT);
				return 1;
			end
		end
		if (dropping || pkt_pos >= pkt_len)
			return 0;
		p = pkt_pos;
		pkt_pos = p + 1;
		last = (p + 1 == pkt_len);

		// header bytes
		if (p < HEADER_BYTES) begin
			prev_low = hdr_bytes[7:0];
			hdr_bytes = {hdr_bytes[119:0], d};
			if (p == 1 && {prev_low, d} != live_cfg.magic_value) begin
				r0 = reject(KIND_BAD_MAGIC);
				return 1;
			end
			if (p == 2 && d != live_cfg.version_value) begin
				r0 = reject(KIND_BAD_VERSION);
				return 1;
			end
			if (p == 3)
				pkt_flags = d;
			if (p == HEADER_BYTES - 1) begin
				r0.kind = KIND_HEADER;
				r0.flags_out = pkt_flags;
				r0.source_hash = hdr_bytes[127:96];
				r0.dest_hash = hdr_bytes[95:64];
				r0.sequence_number = hdr_bytes[63:48];
				r0.timestamp_us = hdr_bytes[47:16];
				r0.device_number = hdr_bytes[15:0];
				r0.packet_end = last;
				return 1;
			end
			return 0;
		end

		// payload bytes
		if (ctx_active) begin
			outs[n] = byte_result(KIND_CONTEXT, d);
			n++;
		end else begin
			fresh = 1'b1;
			// a held type byte is decided by the length byte after it
			if (held_valid) begin
				held_valid = 1'b0;
				if ((p - 1) + int'(d) <= pkt_len && d >= live_cfg.context_min_length) begin
					ctx_active = 1'b1;
					outs[n] = byte_result(KIND_CONTEXT, held_type_byte);
					n++;
					outs[n] = byte_result(KIND_CONTEXT, d);
					n++;
					fresh = 1'b0;
				end else begin
					outs[n] = byte_result(KIND_MIDI, held_type_byte);
					n++;
				end
			end
			if (fresh) begin
				if ((pkt_flags & live_cfg.context_flag_mask) != 8'h00 &&
						d == live_cfg.context_type_code && !last) begin
					held_type_byte = d;
					held_valid = 1'b1;
				end else begin
					outs[n] = byte_result(KIND_MIDI, d);
					n++;
				end
			end
		end
		if (n > 0 && last)
			outs[n - 1].packet_end = 1'b1;
		r0 = outs[0];
		r1 = outs[1];
		return n;
	endfunction

	// fixed expectation for directed rows; the directed header is all ones
	function automatic result_t typed_result(input logic [2:0] k);
		result_t r;
		r = '0;
		r.kind = k;
		r.packet_end = 1'b1;
		if (k == KIND_HEADER) begin
			r.flags_out = '1;
			r.source_hash = '1;
			r.dest_hash = '1;
			r.sequence_number = '1;
			r.timestamp_us = '1;
			r.device_number = '1;
		end
		return r;
	endfunction

	// offer one item, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] d, input logic fb, input logic [15:0] len,
			input logic [2:0] want);
		int      n;
		result_t r0;
		result_t r1;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		data_byte <= d;
		first_byte <= fb;
		packet_length <= len;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		n = parse_byte(d, fb, len, r0, r1);
		if (want != KIND_NONE) begin
			expected_results.insert(expected_results.size(), typed_result(want));
		end else begin
			if (n > 0)
				expected_results.insert(expected_results.size(), r0);
			if (n > 1)
				expected_results.insert(expected_results.size(), r1);
		end
	endtask

	// stop sending and let every result come out
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup and access cycle; psel is left high for a following write
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_MAGIC:    live_cfg.magic_value = value[15:0];
			REG_VERSION:  live_cfg.version_value = value[7:0];
			REG_CTX_MASK: live_cfg.context_flag_mask = value[7:0];
			REG_CTX_TYPE: live_cfg.context_type_code = value[7:0];
			REG_CTX_MIN:  live_cfg.context_min_length = value[7:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input cfg_t c);
		write_reg(REG_MAGIC, {16'h0, c.magic_value});
		write_reg(REG_VERSION, {24'h0, c.version_value});
		write_reg(REG_CTX_MASK, {24'h0, c.context_flag_mask});
		write_reg(REG_CTX_TYPE, {24'h0, c.context_type_code});
		write_reg(REG_CTX_MIN, {24'h0, c.context_min_length});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.magic_value = 16'($urandom());
		c.version_value = rand_byte();
		c.context_flag_mask = 8'($urandom_range(1, 255));
		c.context_type_code = rand_byte();
		c.context_min_length = 8'($urandom_range(0, 12));
		return c;
	endfunction

	// one packet, mostly well formed; sometimes bad, short, or cut off by the next one
	task automatic send_packet(input bit whole, inout int sent);
		int         len;
		int         count;
		int         pick;
		int         room;
		bit         bad_magic;
		bit         bad_version;
		bit         len_next;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			len = $urandom_range(1, HEADER_BYTES - 1);
		else if (pick < 10)
			len = HEADER_BYTES;
		else if (pick < 70)
			len = $urandom_range(HEADER_BYTES + 1, 48);
		else if (pick < 90 || whole)
			len = $urandom_range(49, 300);
		else
			len = $urandom_range(1, 65535);
		count = len;
		if (len < HEADER_BYTES)
			count = $urandom_range(1, 3);
		else if (len > 300)
			count = $urandom_range(1, 60);
		else if (!whole && $urandom_range(0, 99) < 8)
			count = $urandom_range(1, len);
		bad_magic = ($urandom_range(0, 99) < 6);
		bad_version = ($urandom_range(0, 99) < 6);
		len_next = 1'b0;
		for (int p = 0; p < count; p++) begin
			if (p == 0)
				b = bad_magic ? rand_byte() : live_cfg.magic_value[15:8];
			else if (p == 1)
				b = bad_magic ? rand_byte() : live_cfg.magic_value[7:0];
			else if (p == 2)
				b = bad_version ? rand_byte() : live_cfg.version_value;
			else if (p == 3)
				b = $urandom_range(0, 1) ? (rand_byte() | live_cfg.context_flag_mask) :
					rand_byte();
			else if (p < HEADER_BYTES)
				b = rand_byte();
			else if (len_next) begin
				// length byte after an injected type byte, valid more often than not
				room = len - (p - 1);
				if (room > 255)
					room = 255;
				if ($urandom_range(0, 99) < 60 && int'(live_cfg.context_min_length) <= room)
					b = 8'($urandom_range(int'(live_cfg.context_min_length), room));
				else
					b = rand_byte();
				len_next = 1'b0;
			end else if ($urandom_range(0, 99) < 8) begin
				b = live_cfg.context_type_code;
				len_next = 1'b1;
			end else
				b = rand_byte();
			send_byte(b, p == 0, (p == 0) ? 16'(len) : 16'($urandom()), KIND_NONE);
		end
		sent += count;
	endtask

	// one setting of the registers and of the idling
	task automatic run_phase(input int idle_pct, input int stall_pct, input cfg_t c);
		int sent;
		sent = 0;
		wait_idle();
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		program_regs(c);
		while (sent < PHASE_BYTES) begin
			send_packet(1'b0, sent);
			// stray bytes between packets
			if ($urandom_range(0, 99) < 5)
				repeat ($urandom_range(1, 3))
					send_byte(rand_byte(), 1'b0, 16'($urandom()), KIND_NONE);
		end
		send_packet(1'b1, sent);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with none expected: kind %0d", kind);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("kind", want.kind, kind);
				check_field("payload_byte", want.payload_byte, payload_byte);
				check_field("flags_out", want.flags_out, flags_out);
				check_field("source_hash", want.source_hash, source_hash);
				check_field("dest_hash", want.dest_hash, dest_hash);
				check_field("sequence_number", want.sequence_number, sequence_number);
				check_field("timestamp_us", want.timestamp_us, timestamp_us);
				check_field("device_number", want.device_number, device_number);
				check_field("packet_end", want.packet_end, packet_end);
			end
		end
	end

	// stimulus
	initial begin : stimulus
		cfg_t extreme_a;
		cfg_t extreme_b;
		live_cfg = '{16'h0000, 8'h00, 8'h00, 8'h00, CTX_MIN_RESET};
		extreme_a = '{16'hFFFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
		extreme_b = '{16'h0000, 8'h00, 8'h80, 8'hFF, 8'hFF};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows on reset register values
		for (int i = 0; i < 29; i++)
			send_byte(directed_rows[i].data, directed_rows[i].first, directed_rows[i].len,
				directed_rows[i].want);

		run_phase(0, 0, extreme_a);
		run_phase(80, 0, random_cfg());
		run_phase(0, 80, extreme_b);
		run_phase(21, 21, random_cfg());
		wait_idle();

		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
